@@ hw/rtl/indexed_min_heap_queue_unit_assert.svh @@
// Assertion macros used by the heap queue controller RTL.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// plain property, clocked on clk_i, off while rst_ni is low
`define IHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define IHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ihq_pkg.sv @@
// Package for the heap queue: sizes, codes, entry and command types, key and slot index helpers.
package ihq_pkg;

  localparam int CAPACITY = 128;
  localparam int KEY_BITS = 16;

  localparam int ID_W      = 7;
  localparam int ID_COUNT  = 2 ** ID_W;
  localparam int PKEY_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int FUNC_W    = 2;
  localparam int COUNT_W   = 8;

  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int LEVELS    = $clog2(CAPACITY + 1);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CAP_CLOG  = $clog2(CAPACITY);
  localparam int OFS_W     = (CAP_CLOG > 2) ? CAP_CLOG - 1 : 2;
  localparam int ROW_W     = OFS_W - 1;
  localparam int BANK_DEPTH = 2 ** ROW_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    key_t            key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // broadcast to every level cell; a cell acts when the level matches its own
  typedef struct packed {
    logic              rd_en;
    logic [LVL_W-1:0]  rd_lvl;
    logic [ROW_W-1:0]  rd_row;
    logic              rd_hi_ok;
    logic              wr_en;
    logic [LVL_W-1:0]  wr_lvl;
    logic [OFS_W-1:0]  wr_ofs;
    entry_t            wr_entry;
  } cell_cmd_t;

  // sibling pair read from one level, handed down the row towards level 0
  typedef struct packed {
    entry_t lo;
    entry_t hi;
    entry_t min_e;
    logic   min_hi;
  } cell_rsp_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     removed_id;
    key_t                removed_key;
    logic [ID_W-1:0]     top_id;
    key_t                top_key;
    logic [CNT_W-1:0]    count;
    logic                is_empty;
  } res_t;

  function automatic key_t key_from_port(input logic [PKEY_W-1:0] k);
    logic [63:0] w;
    w = 64'(k);
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [PKEY_W-1:0] key_to_port(input key_t k);
    logic [63:0] w;
    w = 64'(k);
    return w[PKEY_W-1:0];
  endfunction

  // heap level of a 1-based slot index (position of the top set bit)
  function automatic logic [LVL_W-1:0] lvl_of(input logic [CNT_W-1:0] i);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (i[b]) l = LVL_W'(b);
    end
    return l;
  endfunction

  // offset of a 1-based slot index within its level
  function automatic logic [OFS_W-1:0] ofs_of(input logic [CNT_W-1:0] i);
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] diff;
    base = CNT_W'(1) << lvl_of(i);
    diff = i - base;
    return OFS_W'(diff);
  endfunction

endpackage

@@ hw/rtl/ihq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ihq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ihq_cell.sv @@
// One heap level: even and odd slot banks, sibling compare, response hand-off.
module ihq_cell import ihq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LVL_W-1:0] lvl_i,
  input  cell_cmd_t        cmd_i,
  input  cell_rsp_t        rsp_i,
  output cell_rsp_t        rsp_o
);

  logic               rd_hit;
  logic               wr_hit;
  logic               we_lo;
  logic               we_hi;
  logic [ROW_W-1:0]   wr_row;
  logic [ENTRY_W-1:0] lo_raw;
  logic [ENTRY_W-1:0] hi_raw;
  entry_t             lo;
  entry_t             hi;
  logic               min_hi;
  logic               hit_q;
  logic               hi_ok_q;

  assign rd_hit = cmd_i.rd_en && (cmd_i.rd_lvl == lvl_i);
  assign wr_hit = cmd_i.wr_en && (cmd_i.wr_lvl == lvl_i);
  assign we_lo  = wr_hit && !cmd_i.wr_ofs[0];
  assign we_hi  = wr_hit && cmd_i.wr_ofs[0];
  assign wr_row = ROW_W'(cmd_i.wr_ofs >> 1);

  ihq_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_lo (
    .clk_i   (clk_i),
    .we_i    (we_lo),
    .waddr_i (wr_row),
    .wdata_i (cmd_i.wr_entry),
    .re_i    (rd_hit),
    .raddr_i (cmd_i.rd_row),
    .rdata_o (lo_raw)
  );

  ihq_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_hi (
    .clk_i   (clk_i),
    .we_i    (we_hi),
    .waddr_i (wr_row),
    .wdata_i (cmd_i.wr_entry),
    .re_i    (rd_hit),
    .raddr_i (cmd_i.rd_row),
    .rdata_o (hi_raw)
  );

  // hit flag holds until the next read anywhere in the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      hi_ok_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      hit_q   <= rd_hit;
      hi_ok_q <= cmd_i.rd_hi_ok;
    end
  end

  assign lo = entry_t'(lo_raw);
  assign hi = entry_t'(hi_raw);

  // left child wins a tie
  assign min_hi = hi_ok_q && (hi.key < lo.key);

  always_comb begin
    if (hit_q) begin
      rsp_o.lo     = lo;
      rsp_o.hi     = hi;
      rsp_o.min_e  = min_hi ? hi : lo;
      rsp_o.min_hi = min_hi;
    end else begin
      rsp_o = rsp_i;
    end
  end

endmodule

@@ hw/rtl/ihq_ctrl.sv @@
// Request sequencer: id map, held count, sift walk over the level cells, result register.
module ihq_ctrl import ihq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] in_func_i,
  input  logic [ID_W-1:0]   in_id_i,
  input  key_t              in_key_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_res_o,
  output cell_cmd_t         cmd_o,
  input  cell_rsp_t         rsp_i
);

`include "indexed_min_heap_queue_unit_assert.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_RM_RD   = 4'd2;
  localparam logic [3:0] S_RM_TGT  = 4'd3;
  localparam logic [3:0] S_RM_LAST = 4'd4;
  localparam logic [3:0] S_DN_RD   = 4'd5;
  localparam logic [3:0] S_DN_CMP  = 4'd6;
  localparam logic [3:0] S_UP_RD   = 4'd7;
  localparam logic [3:0] S_UP_CMP  = 4'd8;
  localparam logic [3:0] S_PLACE   = 4'd9;
  localparam logic [3:0] S_TOP     = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic                moved_q, moved_d;
  logic [ID_COUNT-1:0] map_valid_q, map_valid_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;
  entry_t              token_q, token_d;
  entry_t              removed_q, removed_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [FUNC_W-1:0]   req_func_q;
  logic [ID_W-1:0]     req_id_q;
  key_t                req_key_q;

  logic                accept;
  logic                map_we;
  logic [ID_W-1:0]     map_waddr;
  logic [SLOT_W-1:0]   map_wdata;
  logic [SLOT_W-1:0]   map_rdata;
  cell_cmd_t           cmd;

  logic [LVL_W-1:0]    lvl_pos;
  logic [OFS_W-1:0]    ofs_pos;
  logic [CNT_W-1:0]    par;
  logic [LVL_W-1:0]    lvl_par;
  logic [OFS_W-1:0]    ofs_par;
  logic [LVL_W-1:0]    lvl_last;
  logic [OFS_W-1:0]    ofs_last;
  logic [CNT_W:0]      left_idx;
  logic [CNT_W:0]      right_idx;
  logic [CNT_W:0]      cnt_ext;
  logic [SLOT_W-1:0]   pos_slot;
  entry_t              parent_e;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  ihq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_COUNT)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (accept),
    .raddr_i (in_id_i),
    .rdata_o (map_rdata)
  );

  assign lvl_pos   = lvl_of(pos_q);
  assign ofs_pos   = ofs_of(pos_q);
  assign par       = pos_q >> 1;
  assign lvl_par   = lvl_of(par);
  assign ofs_par   = ofs_of(par);
  assign lvl_last  = lvl_of(count_q);
  assign ofs_last  = ofs_of(count_q);
  assign left_idx  = {pos_q, 1'b0};
  assign right_idx = {pos_q, 1'b1};
  assign cnt_ext   = {1'b0, count_q};
  assign pos_slot  = SLOT_W'(pos_q - CNT_W'(1));
  assign parent_e  = ofs_par[0] ? rsp_i.hi : rsp_i.lo;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    moved_d     = moved_q;
    map_valid_d = map_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    token_d     = token_q;
    removed_d   = removed_q;
    status_d    = status_q;
    map_we      = 1'b0;
    map_waddr   = '0;
    map_wdata   = '0;
    cmd         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d  = ST_OK;
          removed_d = '0;
          moved_d   = 1'b0;
          state_d   = S_DISP;
        end
      end

      S_DISP: begin
        unique case (req_func_q)
          FUNC_INSERT: begin
            if (map_valid_q[req_id_q]) begin
              status_d = ST_DUP;
              state_d  = S_TOP;
            end else if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_TOP;
            end else begin
              token_d.id            = req_id_q;
              token_d.key           = req_key_q;
              pos_d                 = count_q + CNT_W'(1);
              count_d               = count_q + CNT_W'(1);
              map_valid_d[req_id_q] = 1'b1;
              state_d               = S_UP_RD;
            end
          end
          FUNC_DELETE: begin
            if (!map_valid_q[req_id_q] || (CNT_W'(map_rdata) >= count_q)) begin
              status_d = ST_ABSENT;
              state_d  = S_TOP;
            end else begin
              pos_d   = CNT_W'(map_rdata) + CNT_W'(1);
              state_d = S_RM_RD;
            end
          end
          FUNC_EXTRACT: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_TOP;
            end else begin
              pos_d   = CNT_W'(1);
              state_d = S_RM_RD;
            end
          end
          FUNC_PEEK: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end
            state_d = S_TOP;
          end
          default: state_d = S_TOP;
        endcase
      end

      S_RM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_lvl = lvl_pos;
        cmd.rd_row = ROW_W'(ofs_pos >> 1);
        state_d    = S_RM_TGT;
      end

      S_RM_TGT: begin
        removed_d  = ofs_pos[0] ? rsp_i.hi : rsp_i.lo;
        cmd.rd_en  = 1'b1;
        cmd.rd_lvl = lvl_last;
        cmd.rd_row = ROW_W'(ofs_last >> 1);
        state_d    = S_RM_LAST;
      end

      S_RM_LAST: begin
        // last task becomes the token that refills the freed slot
        token_d                   = ofs_last[0] ? rsp_i.hi : rsp_i.lo;
        map_valid_d[removed_q.id] = 1'b0;
        count_d                   = count_q - CNT_W'(1);
        state_d                   = (pos_q == count_q) ? S_TOP : S_DN_RD;
      end

      S_DN_RD: begin
        if (left_idx > cnt_ext) begin
          state_d = moved_q ? S_PLACE : S_UP_RD;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_lvl   = LVL_W'(lvl_pos + LVL_W'(1));
          cmd.rd_row   = ROW_W'(ofs_pos);
          cmd.rd_hi_ok = (right_idx <= cnt_ext);
          state_d      = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        if (rsp_i.min_e.key < token_q.key) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_lvl   = lvl_pos;
          cmd.wr_ofs   = ofs_pos;
          cmd.wr_entry = rsp_i.min_e;
          map_we       = 1'b1;
          map_waddr    = rsp_i.min_e.id;
          map_wdata    = pos_slot;
          pos_d        = CNT_W'({pos_q, rsp_i.min_hi});
          moved_d      = 1'b1;
          state_d      = S_DN_RD;
        end else begin
          // a task that never sank may still have to climb
          state_d = moved_q ? S_PLACE : S_UP_RD;
        end
      end

      S_UP_RD: begin
        if (pos_q == CNT_W'(1)) begin
          state_d = S_PLACE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_lvl = lvl_par;
          cmd.rd_row = ROW_W'(ofs_par >> 1);
          state_d    = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (token_q.key < parent_e.key) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_lvl   = lvl_pos;
          cmd.wr_ofs   = ofs_pos;
          cmd.wr_entry = parent_e;
          map_we       = 1'b1;
          map_waddr    = parent_e.id;
          map_wdata    = pos_slot;
          pos_d        = par;
          state_d      = S_UP_RD;
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_lvl   = lvl_pos;
        cmd.wr_ofs   = ofs_pos;
        cmd.wr_entry = token_q;
        map_we       = 1'b1;
        map_waddr    = token_q.id;
        map_wdata    = pos_slot;
        state_d      = S_TOP;
      end

      S_TOP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_lvl = '0;
        cmd.rd_row = '0;
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status      = status_q;
          out_d.removed_id  = removed_q.id;
          out_d.removed_key = removed_q.key;
          out_d.top_id      = (count_q == '0) ? '0 : rsp_i.lo.id;
          out_d.top_key     = (count_q == '0) ? '0 : rsp_i.lo.key;
          out_d.count       = count_q;
          out_d.is_empty    = (count_q == '0);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      map_valid_q <= '0;
      out_valid_q <= 1'b0;
      moved_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      map_valid_q <= map_valid_d;
      out_valid_q <= out_valid_d;
      moved_q     <= moved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_func_q <= in_func_i;
      req_id_q   <= in_id_i;
      req_key_q  <= in_key_i;
    end
    pos_q     <= pos_d;
    token_q   <= token_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign cmd_o       = cmd;

  `IHQ_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY), "held count beyond capacity")
  `IHQ_ASSERT(a_map_matches_count, $countones(map_valid_q) == int'(count_q), "present ids differ from held count")
  `IHQ_ASSERT_IMP(a_no_rd_wr_clash, cmd.wr_en, !cmd.rd_en, "slot write and read in one cycle")
  `IHQ_ASSERT_IMP(a_climb_in_heap, state_q == S_UP_CMP, pos_q > CNT_W'(1) && pos_q <= count_q, "climb outside heap")
  `IHQ_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "result raised outside done")

endmodule

@@ hw/rtl/indexed_min_heap_queue_unit.sv @@
// Indexed min-heap priority queue: one request at a time, a result register on the output.
// Each sift level takes a read state and a compare state (S_DN_RD/S_DN_CMP, S_UP_RD/S_UP_CMP).
// A new request is not taken until the result of the last one is registered; the next is
// taken the cycle after that, or later while a stalled result still holds the register.
// Reset empties the heap at once: id-present flags and count clear, no memory sweep.
module indexed_min_heap_queue_unit import ihq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [6:0] task_id, [22:7] key, [23] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [6:0] removed_id, [22:7] removed_key, [29:23] top_id, [45:30] top_key,
  // [53:46] count, [54] is_empty, [55] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]    m_axis_tuser
);

  cell_cmd_t cmd;
  cell_rsp_t rsp_chain [LEVELS+1];
  res_t      res;
  key_t      in_key;

  assign in_key = key_from_port(s_axis_tdata[ID_W +: PKEY_W]);

  ihq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_id_i     (s_axis_tdata[ID_W-1:0]),
    .in_key_i    (in_key),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .cmd_o       (cmd),
    .rsp_i       (rsp_chain[0])
  );

  // row of level cells; read data travels from the deep end towards level 0
  assign rsp_chain[LEVELS] = '0;

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    ihq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lvl_i  (LVL_W'(l)),
      .cmd_i  (cmd),
      .rsp_i  (rsp_chain[l+1]),
      .rsp_o  (rsp_chain[l])
    );
  end

  assign m_axis_tdata = {1'b0,
                         res.is_empty,
                         COUNT_W'(res.count),
                         key_to_port(res.top_key),
                         res.top_id,
                         key_to_port(res.removed_key),
                         res.removed_id};
  assign m_axis_tuser = res.status;

endmodule
